[rtl/estg_pkg.sv]
`default_nettype none

package estg_pkg;

  // Register and field widths.
  localparam int STEP_W   = 23;
  localparam int TOTAL_W  = 21;
  localparam int FADE_W   = 12;
  localparam int AMP_W    = 15;
  localparam int MAG_W    = 15;
  localparam int SAMPLE_W = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 23;

  // Register values after reset.
  localparam logic [STEP_W-1:0]  PHASE_STEP_RESET    = 23'd669568;
  localparam logic [TOTAL_W-1:0] TOTAL_SAMPLES_RESET = 21'd1984;
  localparam logic [FADE_W-1:0]  FADE_SAMPLES_RESET  = 12'd110;
  localparam logic [AMP_W-1:0]   AMPLITUDE_RESET     = 15'd19660;

  // Envelope divider: the quotient is built a few bits per pipeline stage.
  localparam int DIV_STAGES    = 5;
  localparam int DIV_STEP_BITS = 3;
  localparam int QUOT_W        = DIV_STAGES * DIV_STEP_BITS;

  // Envelope value of one in Q1.15.
  localparam logic [QUOT_W:0] ENV_ONE = 16'h8000;

  // Pi over two in Q30, used to build the quarter-wave table.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PHASE_STEP    = 2'd0,
    REG_TOTAL_SAMPLES = 2'd1,
    REG_FADE_SAMPLES  = 2'd2,
    REG_AMPLITUDE     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic env_full;
    logic beyond;
    logic last;
  } flags_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    flags_t           flags;
  } side_t;

  // One entry of the quarter-wave table: round(32767 * sin(j*pi/(2Q))) by a
  // seven-term Taylor series in Q30. Only evaluated when the design is built.
  // The divisors are the factorial ratios (2k)(2k+1) for k from one to six.
  function automatic logic [MAG_W-1:0] quarter_entry(input int unsigned j,
                                                     input int unsigned tb);
    longint unsigned jj;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned v;
    jj = j;
    x = (jj * HALF_PI_Q30) >> (tb - 2);
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + term;
    v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/estg_front.sv]
`default_nettype none

module estg_front #(
  parameter int INDEX_BITS      = 21,
  parameter int PHASE_BITS      = 24,
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           req_valid,
  input  wire  [INDEX_BITS-1:0]         req_index,
  input  wire  [estg_pkg::STEP_W-1:0]   phase_step,
  input  wire  [estg_pkg::TOTAL_W-1:0]  total_samples,
  input  wire  [estg_pkg::FADE_W-1:0]   fade,
  output logic                          addr_valid,
  output logic [SINE_TABLE_BITS-1:0]    addr,
  output logic [estg_pkg::FADE_W-1:0]   numer,
  output estg_pkg::flags_t              flags
);

  import estg_pkg::*;

  localparam int IW     = (INDEX_BITS > TOTAL_W) ? INDEX_BITS : TOTAL_W;
  localparam int PROD_W = INDEX_BITS + STEP_W;

  logic [PROD_W-1:0] phase_prod;
  logic [IW-1:0]     idx_z;
  logic [IW-1:0]     total_z;
  logic [IW-1:0]     remaining;
  logic              attack;
  logic              release_zone;
  logic              beyond;
  logic              last;

  assign phase_prod = PROD_W'(req_index) * PROD_W'(phase_step);

  assign idx_z     = IW'(req_index);
  assign total_z   = IW'(total_samples);
  assign remaining = total_z - idx_z;

  assign beyond = idx_z >= total_z;
  assign last   = ({1'b0, idx_z} + (IW + 1)'(1)) == {1'b0, total_z};
  assign attack = idx_z < IW'(fade);
  // Inside the release ramp when index + fade passes the total length.
  assign release_zone = ({1'b0, idx_z} + (IW + 1)'(fade)) > {1'b0, total_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_valid <= 1'b0;
    end else begin
      addr_valid <= req_valid;
    end
  end

  // Both numerators stay below the fade length whenever they are used.
  always_ff @(posedge clk) begin
    addr           <= phase_prod[PHASE_BITS-1 -: SINE_TABLE_BITS];
    numer          <= attack ? idx_z[FADE_W-1:0] : remaining[FADE_W-1:0];
    flags.env_full <= !attack && !release_zone;
    flags.beyond   <= beyond;
    flags.last     <= last;
  end

endmodule

`default_nettype wire

[rtl/estg_sine.sv]
`default_nettype none

module estg_sine #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          addr_valid,
  input  wire  [SINE_TABLE_BITS-1:0]   addr,
  input  wire  [estg_pkg::FADE_W-1:0]  numer,
  input  estg_pkg::flags_t             flags,
  output logic                         mag_valid,
  output logic [estg_pkg::FADE_W-1:0]  mag_numer,
  output estg_pkg::side_t              side
);

  import estg_pkg::*;

  localparam int QSIZE = 1 << (SINE_TABLE_BITS - 2);
  localparam logic [SINE_TABLE_BITS-2:0] QSIZE_K = (SINE_TABLE_BITS - 1)'(QSIZE);
  localparam logic [MAG_W-1:0] PEAK_ENTRY = quarter_entry(QSIZE, SINE_TABLE_BITS);

  logic [MAG_W-1:0]           rom [QSIZE];
  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-3:0] off;
  logic [SINE_TABLE_BITS-2:0] kk;

  for (genvar j = 0; j < QSIZE; j++) begin : g_rom
    localparam logic [MAG_W-1:0] ENTRY = quarter_entry(j, SINE_TABLE_BITS);
    assign rom[j] = ENTRY;
  end

  assign quad = addr[SINE_TABLE_BITS-1 -: 2];
  assign off  = addr[SINE_TABLE_BITS-3:0];
  // Odd quadrants read the table backwards; an offset of zero there lands on
  // the peak, which lies one past the stored entries.
  assign kk   = quad[0] ? (QSIZE_K - {1'b0, off}) : {1'b0, off};

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
    end else begin
      mag_valid <= addr_valid;
    end
  end

  always_ff @(posedge clk) begin
    side.mag   <= kk[SINE_TABLE_BITS-2] ? PEAK_ENTRY : rom[kk[SINE_TABLE_BITS-3:0]];
    side.neg   <= quad[1];
    side.flags <= flags;
    mag_numer  <= numer;
  end

endmodule

`default_nettype wire

[rtl/estg_div.sv]
`default_nettype none

module estg_div (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          numer_valid,
  input  wire  [estg_pkg::FADE_W-1:0]  numer,
  input  wire  [estg_pkg::FADE_W-1:0]  divisor,
  input  estg_pkg::side_t              numer_side,
  output logic                         quot_valid,
  output logic [estg_pkg::QUOT_W-1:0]  quot,
  output estg_pkg::side_t              quot_side
);

  import estg_pkg::*;

  // Restoring division of numer * 2^15 by the divisor. The numerator is
  // below the divisor whenever the quotient is used, so it then fits in fifteen bits and the
  // partial remainder never needs more than the divisor's width.
  logic              stage_valid [DIV_STAGES];
  logic [QUOT_W-1:0] stage_quot  [DIV_STAGES];
  side_t             stage_side  [DIV_STAGES];
  logic [FADE_W-1:0] stage_rem   [DIV_STAGES-1];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic              v_in;
    logic [FADE_W-1:0] r_in;
    logic [QUOT_W-1:0] q_in;
    side_t             side_in;
    logic [FADE_W-1:0] r_next;
    logic [QUOT_W-1:0] q_next;

    if (s == 0) begin : g_first
      assign v_in    = numer_valid;
      assign r_in    = numer;
      assign q_in    = '0;
      assign side_in = numer_side;
    end else begin : g_rest
      assign v_in    = stage_valid[s-1];
      assign r_in    = stage_rem[s-1];
      assign q_in    = stage_quot[s-1];
      assign side_in = stage_side[s-1];
    end

    always_comb begin
      logic [FADE_W:0] t;
      r_next = r_in;
      q_next = q_in;
      for (int b = 0; b < DIV_STEP_BITS; b++) begin
        t = {r_next, 1'b0};
        if (t >= {1'b0, divisor}) begin
          r_next = FADE_W'(t - {1'b0, divisor});
          q_next = {q_next[QUOT_W-2:0], 1'b1};
        end else begin
          r_next = t[FADE_W-1:0];
          q_next = {q_next[QUOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[s] <= 1'b0;
      end else begin
        stage_valid[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      stage_quot[s] <= q_next;
      stage_side[s] <= side_in;
    end

    // The last stage has no use for the remainder.
    if (s < DIV_STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        stage_rem[s] <= r_next;
      end
    end
  end

  assign quot_valid = stage_valid[DIV_STAGES-1];
  assign quot       = stage_quot[DIV_STAGES-1];
  assign quot_side  = stage_side[DIV_STAGES-1];

endmodule

`default_nettype wire

[rtl/estg_scale.sv]
`default_nettype none

module estg_scale (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          quot_valid,
  input  wire  [estg_pkg::QUOT_W-1:0]  quot,
  input  estg_pkg::side_t              quot_side,
  input  wire  [estg_pkg::AMP_W-1:0]   amplitude,
  output logic                         level_valid,
  output logic [estg_pkg::MAG_W-1:0]   level,
  output estg_pkg::side_t              level_side
);

  import estg_pkg::*;

  localparam int P1_W = MAG_W + QUOT_W + 1;
  localparam int P2_W = MAG_W + AMP_W;

  logic [QUOT_W:0]   env;
  logic [P1_W-1:0]   prod_env;
  logic [P2_W-1:0]   prod_amp;
  logic              env_valid;
  logic [MAG_W-1:0]  env_mag;
  side_t             env_side;

  assign env      = quot_side.flags.env_full ? ENV_ONE : {1'b0, quot};
  assign prod_env = P1_W'(quot_side.mag) * P1_W'(env);
  assign prod_amp = P2_W'(env_mag) * P2_W'(amplitude);

  always_ff @(posedge clk) begin
    if (rst) begin
      env_valid   <= 1'b0;
      level_valid <= 1'b0;
    end else begin
      env_valid   <= quot_valid;
      level_valid <= env_valid;
    end
  end

  // Both products are shifted down by fifteen; neither result exceeds 32767.
  always_ff @(posedge clk) begin
    env_mag    <= prod_env[15 +: MAG_W];
    env_side   <= quot_side;
    level      <= prod_amp[15 +: MAG_W];
    level_side <= env_side;
  end

endmodule

`default_nettype wire

[rtl/enveloped_sine_tone_generator.sv]
// Sine tone generator with a linear attack and release envelope. Each word
// on sample_index, taken when start is high and busy is low, yields exactly
// one word on sample, beyond_end and is_last, marked by done for a single
// cycle once the index has passed through the pipeline; a new index may
// be given in every cycle and busy never rises, since nothing inside can
// stall. The receiver cannot hold results off, so it must take each word in
// the cycle that done is high.
// The pipeline holds the envelope divider, five stages that each find
// three quotient bits, plus the input register, the phase multiply, the
// sine table read, the two scaling multiplies and the output register.
// The configuration channel accepts a write in every cycle; a register
// should be written only while no sample is in flight.

`default_nettype none

module enveloped_sine_tone_generator #(
  parameter int PHASE_BITS      = 24,
  parameter int SINE_TABLE_BITS = 10,
  parameter int INDEX_BITS      = 21
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire  [INDEX_BITS-1:0]              sample_index,
  output logic                               done,
  output logic signed [estg_pkg::SAMPLE_W-1:0] sample,
  output logic                               beyond_end,
  output logic                               is_last,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [estg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire  [estg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import estg_pkg::*;

  localparam int LATENCY = DIV_STAGES + 6;

  logic [STEP_W-1:0]           phase_step;
  logic [TOTAL_W-1:0]          total_samples;
  logic [FADE_W-1:0]           fade_samples;
  logic [AMP_W-1:0]            amplitude;
  logic [FADE_W-1:0]           fade;

  logic                        req_valid;
  logic [INDEX_BITS-1:0]       req_index;

  logic                        addr_valid;
  logic [SINE_TABLE_BITS-1:0]  addr;
  logic [FADE_W-1:0]           numer;
  flags_t                      flags;

  logic                        mag_valid;
  logic [FADE_W-1:0]           mag_numer;
  side_t                       mag_side;

  logic                        quot_valid;
  logic [QUOT_W-1:0]           quot;
  side_t                       quot_side;

  logic                        level_valid;
  logic [MAG_W-1:0]            level;
  side_t                       level_side;
  logic [SAMPLE_W-1:0]         level_ext;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // A fade length of zero behaves as one.
  assign fade = (fade_samples == '0) ? FADE_W'(1) : fade_samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= PHASE_STEP_RESET;
      total_samples <= TOTAL_SAMPLES_RESET;
      fade_samples  <= FADE_SAMPLES_RESET;
      amplitude     <= AMPLITUDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PHASE_STEP:    phase_step    <= cfg_data[STEP_W-1:0];
        REG_TOTAL_SAMPLES: total_samples <= cfg_data[TOTAL_W-1:0];
        REG_FADE_SAMPLES:  fade_samples  <= cfg_data[FADE_W-1:0];
        REG_AMPLITUDE:     amplitude     <= cfg_data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    req_index <= sample_index;
  end

  estg_front #(
    .INDEX_BITS      (INDEX_BITS),
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_index     (req_index),
    .phase_step    (phase_step),
    .total_samples (total_samples),
    .fade          (fade),
    .addr_valid    (addr_valid),
    .addr          (addr),
    .numer         (numer),
    .flags         (flags)
  );

  estg_sine #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine (
    .clk        (clk),
    .rst        (rst),
    .addr_valid (addr_valid),
    .addr       (addr),
    .numer      (numer),
    .flags      (flags),
    .mag_valid  (mag_valid),
    .mag_numer  (mag_numer),
    .side       (mag_side)
  );

  estg_div u_div (
    .clk         (clk),
    .rst         (rst),
    .numer_valid (mag_valid),
    .numer       (mag_numer),
    .divisor     (fade),
    .numer_side  (mag_side),
    .quot_valid  (quot_valid),
    .quot        (quot),
    .quot_side   (quot_side)
  );

  estg_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .quot_valid  (quot_valid),
    .quot        (quot),
    .quot_side   (quot_side),
    .amplitude   (amplitude),
    .level_valid (level_valid),
    .level       (level),
    .level_side  (level_side)
  );

  assign level_ext = {1'b0, level};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= level_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (level_side.flags.beyond) begin
      sample <= '0;
    end else if (level_side.neg) begin
      sample <= SAMPLE_W'(16'd0 - level_ext);
    end else begin
      sample <= level_ext;
    end
    beyond_end <= level_side.flags.beyond;
    is_last    <= level_side.flags.last;
  end

  // Every accepted index produces its word after the fixed latency.
  a_word_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted index produced no word after the pipeline latency");

  // No word appears without an index accepted the latency earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("word delivered without a matching accepted index");

  // Past the end the sample is silent and the last flag stays low.
  a_beyond_silent: assert property (@(posedge clk) disable iff (rst)
    (done && beyond_end) |-> (sample == '0 && !is_last))
    else $error("beyond-end word carries a sample or a last flag");

endmodule

`default_nettype wire

[verif/tb_enveloped_sine_tone_generator.sv]
`timescale 1ns / 100ps

module tb_enveloped_sine_tone_generator;
  import estg_pkg::*;

  localparam int PHASE_BITS      = 24;
  localparam int SINE_TABLE_BITS = 10;
  localparam int INDEX_BITS      = 21;
  localparam int QUARTER         = 1 << (SINE_TABLE_BITS - 2);
  localparam int MAX_CYCLES      = 400000;
  localparam int MAX_REPORTS     = 10;
  localparam int RANDOM_SETS     = 6;
  localparam int SET_WORDS       = 121;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       beyond_end;
    logic                       is_last;
  } tone_word_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [INDEX_BITS-1:0]   sample_index = '0;
  logic                    done;
  logic signed [SAMPLE_W-1:0] sample;
  logic                    beyond_end;
  logic                    is_last;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  // Copy of the register file as the block should hold it.
  logic [STEP_W-1:0]  step_q  = PHASE_STEP_RESET;
  logic [TOTAL_W-1:0] total_q = TOTAL_SAMPLES_RESET;
  logic [FADE_W-1:0]  fade_q  = FADE_SAMPLES_RESET;
  logic [AMP_W-1:0]   amp_q   = AMPLITUDE_RESET;

  longint unsigned quarter_sine [0:QUARTER];

  logic [INDEX_BITS-1:0] pending_indexes [$];
  tone_word_t            expected_words [$];
  int                    gap_left = 0;
  logic                  gaps_on = 1'b1;
  int                    errors = 0;
  int                    cycle_count = 0;

  enveloped_sine_tone_generator #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .INDEX_BITS      (INDEX_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample_index (sample_index),
    .done         (done),
    .sample       (sample),
    .beyond_end   (beyond_end),
    .is_last      (is_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Quarter-wave entry by a seven-term Taylor series in Q30, rounded to Q1.15.
  function automatic longint unsigned sine_entry(input int unsigned j);
    longint unsigned angle;
    longint unsigned angle_sq;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned level;
    angle = (longint'(j) * 64'd1686629713) >> (SINE_TABLE_BITS - 2);
    angle_sq = (angle * angle) >> 30;
    term = angle;
    acc = angle;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * angle_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
      acc = (n % 2 == 1) ? acc - term : acc + term;
    end
    level = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
    return (level > 64'd32767) ? 64'd32767 : level;
  endfunction

  function automatic tone_word_t predict_tone(input logic [INDEX_BITS-1:0] index_in);
    tone_word_t      w;
    longint unsigned idx;
    longint unsigned total;
    longint unsigned fade;
    longint unsigned phase;
    longint unsigned addr;
    longint unsigned quad;
    longint unsigned offs;
    longint unsigned mag;
    longint unsigned env;
    idx = index_in;
    total = total_q;
    fade = (fade_q == '0) ? 1 : fade_q;
    w.sample = '0;
    w.beyond_end = 1'b1;
    w.is_last = 1'b0;
    if (idx >= total) begin
      return w;
    end
    phase = (idx * longint'(step_q)) & ((64'd1 << PHASE_BITS) - 1);
    addr = phase >> (PHASE_BITS - SINE_TABLE_BITS);
    quad = (addr >> (SINE_TABLE_BITS - 2)) & 3;
    offs = addr & (QUARTER - 1);
    mag = quarter_sine[(quad & 1) != 0 ? QUARTER - offs : offs];
    // The release test is an unsigned compare, written without subtraction.
    if (idx < fade) begin
      env = (idx * 32768) / fade;
    end else if (idx + fade > total) begin
      env = ((total - idx) * 32768) / fade;
    end else begin
      env = 32768;
    end
    mag = (mag * env) >> 15;
    mag = (mag * longint'(amp_q)) >> 15;
    w.sample = ((quad & 2) != 0) ? -mag[SAMPLE_W-1:0] : mag[SAMPLE_W-1:0];
    w.beyond_end = 1'b0;
    w.is_last = (idx + 1 == total);
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 30);
  endfunction

  // Driver: one word is offered at a time and held until start and not busy meet.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (!(start && busy)) begin
      if (start) begin
        expected_words.push_back(predict_tone(sample_index));
      end
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_indexes.size() > 0) begin
        start <= 1'b1;
        sample_index <= pending_indexes.pop_front();
        gap_left <= gaps_on ? pick_gap() : 0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every word marked by done is checked against the oldest prediction.
  always @(posedge clk) begin
    tone_word_t want;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        errors <= errors + 1;
        if (errors < MAX_REPORTS) begin
          $display("unexpected word: sample %0d beyond_end %0b is_last %0b",
                   sample, beyond_end, is_last);
        end
      end else begin
        want = expected_words.pop_front();
        if (sample !== want.sample || beyond_end !== want.beyond_end ||
            is_last !== want.is_last) begin
          errors <= errors + 1;
          if (errors < MAX_REPORTS) begin
            $display("mismatch: expected sample %0d beyond_end %0b is_last %0b, got %0d %0b %0b",
                     want.sample, want.beyond_end, want.is_last,
                     sample, beyond_end, is_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Called at a rising edge; leaves valid high so that writes can follow back to back.
  task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (which)
      REG_PHASE_STEP:    step_q = data[STEP_W-1:0];
      REG_TOTAL_SAMPLES: total_q = data[TOTAL_W-1:0];
      REG_FADE_SAMPLES:  fade_q = data[FADE_W-1:0];
      REG_AMPLITUDE:     amp_q = data[AMP_W-1:0];
      default: ;
    endcase
  endtask

  // The upper bits of the length, fade and amplitude writes are random, since the block should ignore them.
  task automatic load_tone(input logic [STEP_W-1:0] step, input logic [TOTAL_W-1:0] total,
                           input logic [FADE_W-1:0] fade, input logic [AMP_W-1:0] amp);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_TOTAL_SAMPLES, {junk[CFG_DATA_W-1:TOTAL_W], total});
    write_reg(REG_FADE_SAMPLES, {junk[CFG_DATA_W-1:FADE_W], fade});
    write_reg(REG_AMPLITUDE, {junk[CFG_DATA_W-1:AMP_W], amp});
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_indexes.size() != 0 || start || expected_words.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [INDEX_BITS-1:0] pick_index();
    longint total;
    longint fade;
    longint spot;
    int     r;
    total = total_q;
    fade = fade_q;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      spot = $urandom_range(0, (total > 4000) ? 4000 : int'(total) + 4);
      if (total > 4000 && $urandom_range(0, 1) == 1) begin
        spot = total - spot;
      end
    end else if (r < 8) begin
      case ($urandom_range(0, 3))
        0: spot = fade;
        1: spot = total - fade;
        2: spot = total - 1;
        default: spot = total;
      endcase
      spot = spot + $urandom_range(0, 6) - 3;
    end else begin
      spot = $urandom;
    end
    return spot[INDEX_BITS-1:0];
  endfunction

  initial begin
    logic [STEP_W-1:0]  step;
    logic [TOTAL_W-1:0] total;
    logic [FADE_W-1:0]  fade;
    logic [AMP_W-1:0]   amp;
    int                 r;

    for (int j = 0; j <= QUARTER; j++) begin
      quarter_sine[j] = sine_entry(j);
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Settings after reset: attack, sustain, release and the end of the tone.
    pending_indexes = '{21'd0, 21'd1, 21'd109, 21'd110, 21'd111, 21'd1873, 21'd1874,
                        21'd1875, 21'd1982, 21'd1983, 21'd1984, 21'd1985, 21'h1FFFFF};
    wait_idle();

    // An empty tone with a zero fade: every index lies past the end.
    load_tone('0, '0, '0, '0);
    pending_indexes = '{21'd0, 21'd5, 21'h1FFFFF};
    wait_idle();

    // Every register at its largest value.
    load_tone('1, '1, '1, '1);
    pending_indexes = '{21'd0, 21'd4094, 21'd4095, 21'd2093056, 21'd2097149, 21'd2097150};
    wait_idle();

    // A zero fade acts as a fade of one: only index zero is ramped, the last sample is at full level.
    load_tone(23'd1398101, 21'd10, '0, 15'd32767);
    pending_indexes = '{21'd0, 21'd1, 21'd5, 21'd9, 21'd10};
    wait_idle();

    for (int s = 0; s < RANDOM_SETS; s++) begin
      r = $urandom_range(0, 9);
      step = (r == 0) ? '0 : (r == 1) ? '1 :
             STEP_W'((r < 5) ? $urandom_range(0, 1 << 20) : $urandom);
      r = $urandom_range(0, 9);
      total = TOTAL_W'((r == 0) ? $urandom_range(0, 2) :
                       (r < 3) ? $urandom : $urandom_range(3, 3000));
      r = $urandom_range(0, 9);
      fade = (r == 0) ? '0 : FADE_W'((r < 3) ? $urandom : $urandom_range(1, 300));
      r = $urandom_range(0, 9);
      amp = (r == 0) ? '0 : (r < 3) ? '1 : AMP_W'($urandom);
      load_tone(step, total, fade, amp);
      gaps_on <= (s % 3 != 1);
      for (int n = 0; n < SET_WORDS; n++) begin
        pending_indexes.push_back(pick_index());
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/estg_pkg.sv
rtl/estg_front.sv
rtl/estg_sine.sv
rtl/estg_div.sv
rtl/estg_scale.sv
rtl/enveloped_sine_tone_generator.sv
verif/tb_enveloped_sine_tone_generator.sv
